[src/vlan_ingress_policer_assert.svh]
// assertion macros for the vlan ingress policer
`ifndef VLAN_INGRESS_POLICER_ASSERT_SVH
`define VLAN_INGRESS_POLICER_ASSERT_SVH
`ifndef SYNTHESIS
`define VIP_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define VIP_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define VIP_ASSERT_IMPL(label, clk, rst_n, a, c)
`define VIP_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[src/vip_pkg.sv]
// types and constants of the vlan ingress policer
`timescale 1ns / 1ps
package vip_pkg;
	localparam int NUM_VLANS = 256;
	localparam int NUM_PORTS = 8;
	localparam int TOKEN_BITS = 24;
	localparam int VIDX_W = $clog2(NUM_VLANS);
	localparam int SCALE_SHIFT = 8;

	typedef enum logic [3:0] {
		REQ_PACKET = 4'd0, REQ_TICK = 4'd1, REQ_SET_MASK = 4'd2, REQ_JOIN = 4'd3,
		REQ_LEAVE = 4'd4, REQ_SET_RATE = 4'd5, REQ_READ_MASK = 4'd6,
		REQ_SET_PORT = 4'd7, REQ_RESET = 4'd8
	} req_e;

	typedef enum logic [1:0] {
		DROP_NONE = 2'd0, DROP_RULE = 2'd1, DROP_RATE = 2'd2
	} drop_e;

	typedef enum logic [1:0] {
		TAG_ALL = 2'd0, TAG_RESTRICT = 2'd1, TAG_PRIORITY = 2'd2, TAG_MANDATORY = 2'd3
	} tag_e;

	typedef enum logic [1:0] {
		RATE_UNLIM = 2'd0, RATE_DEMOTE = 2'd1, RATE_STRICT = 2'd2, RATE_AUTO = 2'd3
	} rate_e;

	typedef enum logic [1:0] {
		ADDR_LOCK_MODE = 2'd0, ADDR_LOCK_RATE = 2'd1, ADDR_LOCK_MAX = 2'd2
	} reg_e;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_SWEEP_RD, ST_SWEEP_WR, ST_OUT
	} state_e;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [11:0] vid;
		logic        dei;
		logic [2:0]  pcp;
		logic [2:0]  port;
		logic [15:0] pkt_length;
		logic [7:0]  port_mask;
		logic [2:0]  mode;
		logic [23:0] tok_refill;
		logic [23:0] tok_max;
	} in_word_t;

	typedef struct packed {
		logic       forward;
		logic [1:0] drop_reason;
		logic [2:0] priority_res;
		logic [7:0] dest_mask;
	} out_word_t;

	typedef struct packed {
		logic [NUM_PORTS-1:0]  members;
		logic [2:0]            rate_mode;
		logic [TOKEN_BITS-1:0] refill;
		logic [TOKEN_BITS-1:0] limit;
		logic [TOKEN_BITS-1:0] tokens;
	} entry_t;
endpackage

[src/vlan_ingress_policer.sv]
// vlan ingress filter with per-vlan token bucket policing
//
//  channel  | handshake        | payload
//  in       | in_valid/in_stall | vip_pkg::in_word_t
//  out      | out_valid/out_stall | vip_pkg::out_word_t
//  cfg      | apb psel/penable | lock mode, rate, limit
//
// a packet or table edit: table read (ST_READ), modify and write with result load
// (ST_EXEC), then ST_OUT sets the out_valid register
// tick and reset words sweep the vlan table, each entry read in ST_SWEEP_RD and written
// in ST_SWEEP_WR; after the last entry ST_OUT sets the out_valid register
// after arst_n a clearing pass of NUM_VLANS entries takes no word
// a result waits in the output register under out_stall; the next word waits for it
`timescale 1ns / 1ps
`include "vlan_ingress_policer_assert.svh"
module vlan_ingress_policer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vip_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output vip_pkg::out_word_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int VW = vip_pkg::VIDX_W;
	localparam int NP = vip_pkg::NUM_PORTS;
	localparam int TB = vip_pkg::TOKEN_BITS;

	// configuration registers
	logic [2:0]  lock_mode_q;
	logic [23:0] lock_rate_q, lock_max_q;
	logic        cfg_wr;
	vip_pkg::reg_e cfg_idx;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = vip_pkg::reg_e'(paddr[3:2]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_mode_q <= 3'd2;
			lock_rate_q <= 24'd1;
			lock_max_q  <= 24'd1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				vip_pkg::ADDR_LOCK_MODE: lock_mode_q <= pwdata[2:0];
				vip_pkg::ADDR_LOCK_RATE: lock_rate_q <= pwdata[23:0];
				vip_pkg::ADDR_LOCK_MAX:  lock_max_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		prdata = 32'd0;
		case (cfg_idx)
			vip_pkg::ADDR_LOCK_MODE: prdata = {29'd0, lock_mode_q};
			vip_pkg::ADDR_LOCK_RATE: prdata = {8'd0, lock_rate_q};
			vip_pkg::ADDR_LOCK_MAX:  prdata = {8'd0, lock_max_q};
			default: prdata = 32'd0;
		endcase
	end

	// port settings in flip-flops
	logic [1:0]  pol_q  [NP];
	logic [11:0] dvid_q [NP];
	logic [2:0]  dpcp_q [NP];

	// vlan table memory
	vip_pkg::entry_t mem [vip_pkg::NUM_VLANS];
	vip_pkg::entry_t rd_q;
	logic [VW-1:0]   rd_addr, wr_addr;
	logic            wr_en;
	vip_pkg::entry_t wr_data;
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// control
	vip_pkg::state_e state_q, state_d;
	vip_pkg::in_word_t req_q;
	logic [VW:0]     sweep_q, sweep_d;
	logic            lock_q, lock_d;
	logic            in_ok_q, in_ok_d;
	vip_pkg::out_word_t res_q, res_d;
	logic            out_valid_q;
	logic            ld_req, ld_res;
	logic            port_ok;
	logic [11:0]     dvid;
	logic            vid_ok;
	logic [VW-1:0]   vidx;
	logic [2:0]      prio;
	logic            admit;
	logic [TB-1:0]   cost;
	logic [TB:0]     sum;
	vip_pkg::entry_t nxt;
	logic            do_wr;
	vip_pkg::req_e   rq;
	logic [1:0]      vpol;
	logic [16:0]     lenp;

	assign in_stall = !(state_q == vip_pkg::ST_IDLE && !out_valid_q);
	assign out_valid = out_valid_q;
	assign out_data = res_q;
	assign rq = vip_pkg::req_e'(req_q.req_type);

	// request decode on the held item
	always_comb begin
		port_ok = {1'b0, req_q.port} < 4'(NP);
		dvid = req_q.vid != 12'd0 ? req_q.vid :
			(port_ok ? dvid_q[req_q.port] : 12'd0);
		vid_ok = (rq == vip_pkg::REQ_PACKET ? dvid : req_q.vid) != 12'd0 &&
			(rq == vip_pkg::REQ_PACKET ? dvid : req_q.vid) <= 12'(vip_pkg::NUM_VLANS);
		vidx = VW'((rq == vip_pkg::REQ_PACKET ? dvid : req_q.vid) - 12'd1);
		prio = req_q.pcp != 3'd0 ? req_q.pcp :
			(port_ok ? dpcp_q[req_q.port] : 3'd0);
		admit = port_ok && vid_ok;
		if (port_ok) begin
			case (vip_pkg::tag_e'(pol_q[req_q.port]))
				vip_pkg::TAG_RESTRICT, vip_pkg::TAG_PRIORITY:
					admit = admit && req_q.vid == 12'd0;
				vip_pkg::TAG_MANDATORY: admit = admit && req_q.vid != 12'd0;
				default: ;
			endcase
		end
		// token cost, rounded up when the vlan counts in 256 byte units
		lenp = {1'b0, req_q.pkt_length} + 17'd255;
		cost = rd_q.rate_mode[2] ? TB'(lenp[16:vip_pkg::SCALE_SHIFT]) :
			TB'(req_q.pkt_length);
	end

	// state machine and modify logic
	always_comb begin
		state_d = state_q;
		sweep_d = sweep_q;
		lock_d = lock_q;
		in_ok_d = 1'b0;
		res_d = res_q;
		ld_req = 1'b0;
		ld_res = 1'b0;
		rd_addr = vidx;
		wr_addr = vidx;
		wr_en = 1'b0;
		nxt = rd_q;
		do_wr = 1'b0;
		vpol = rd_q.rate_mode[1:0];
		sum = {1'b0, rd_q.tokens} + {1'b0, rd_q.refill};
		wr_data = rd_q;
		case (state_q)
			vip_pkg::ST_IDLE: begin
				if (in_valid && !in_stall) begin
					ld_req = 1'b1;
					if (vip_pkg::req_e'(in_data.req_type) == vip_pkg::REQ_TICK ||
						vip_pkg::req_e'(in_data.req_type) == vip_pkg::REQ_RESET) begin
						state_d = vip_pkg::ST_SWEEP_RD;
						sweep_d = '0;
						lock_d = in_data.mode[0];
					end else begin
						state_d = vip_pkg::ST_READ;
					end
				end
			end
			vip_pkg::ST_READ: begin
				state_d = vip_pkg::ST_EXEC;
			end
			vip_pkg::ST_EXEC: begin
				state_d = vip_pkg::ST_OUT;
				res_d = '0;
				ld_res = 1'b1;
				case (rq)
					vip_pkg::REQ_PACKET: begin
						res_d.priority_res = prio;
						if (!admit || !rd_q.members[req_q.port[$clog2(NP)-1:0]]) begin
							res_d.drop_reason = vip_pkg::DROP_RULE;
						end else begin
							res_d.forward = 1'b1;
							res_d.dest_mask = 8'(rd_q.members);
							if (cost > rd_q.tokens) begin
								if (vpol == vip_pkg::RATE_DEMOTE || vpol == vip_pkg::RATE_AUTO)
									res_d.priority_res = 3'd0;
								if (vpol == vip_pkg::RATE_STRICT ||
									(vpol == vip_pkg::RATE_AUTO && req_q.dei)) begin
									res_d.forward = 1'b0;
									res_d.drop_reason = vip_pkg::DROP_RATE;
								end
							end else if (vpol != vip_pkg::RATE_UNLIM) begin
								nxt.tokens = rd_q.tokens - cost;
								do_wr = 1'b1;
							end
						end
					end
					vip_pkg::REQ_SET_MASK: begin
						nxt.members = req_q.port_mask[NP-1:0];
						do_wr = vid_ok;
					end
					vip_pkg::REQ_JOIN: begin
						nxt.members[req_q.port] = 1'b1;
						do_wr = vid_ok && port_ok;
					end
					vip_pkg::REQ_LEAVE: begin
						nxt.members[req_q.port] = 1'b0;
						do_wr = vid_ok && port_ok;
					end
					vip_pkg::REQ_SET_RATE: begin
						nxt.rate_mode = req_q.mode;
						nxt.refill = TB'(req_q.tok_refill);
						nxt.limit = TB'(req_q.tok_max);
						nxt.tokens = TB'(req_q.tok_max);
						do_wr = vid_ok;
					end
					vip_pkg::REQ_READ_MASK: begin
						res_d.dest_mask = vid_ok ? 8'(rd_q.members) : 8'd0;
					end
					default: ;
				endcase
				wr_en = do_wr;
				wr_data = nxt;
			end
			vip_pkg::ST_SWEEP_RD: begin
				rd_addr = sweep_q[VW-1:0];
				state_d = vip_pkg::ST_SWEEP_WR;
				in_ok_d = in_ok_q;
			end
			vip_pkg::ST_SWEEP_WR: begin
				wr_addr = sweep_q[VW-1:0];
				wr_en = 1'b1;
				if (rq == vip_pkg::REQ_TICK) begin
					wr_data.tokens = sum > {1'b0, rd_q.limit} ? rd_q.limit : sum[TB-1:0];
				end else if (lock_q) begin
					wr_data = '{members: '0, rate_mode: lock_mode_q,
						refill: TB'(lock_rate_q), limit: TB'(lock_max_q), tokens: '0};
				end else begin
					wr_data = '{members: '1, rate_mode: 3'd0, refill: '0, limit: '0,
						tokens: '0};
				end
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == (VW+1)'(vip_pkg::NUM_VLANS - 1)) begin
					state_d = in_ok_q ? vip_pkg::ST_IDLE : vip_pkg::ST_OUT;
					res_d = '0;
					ld_res = !in_ok_q;
				end else begin
					state_d = vip_pkg::ST_SWEEP_RD;
					in_ok_d = in_ok_q;
				end
			end
			vip_pkg::ST_OUT: begin
				state_d = vip_pkg::ST_IDLE;
			end
			default: state_d = vip_pkg::ST_IDLE;
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vip_pkg::ST_SWEEP_RD;
			sweep_q <= '0;
			lock_q <= 1'b0;
			in_ok_q <= 1'b1;
			out_valid_q <= 1'b0;
			req_q <= '0;
			for (int p = 0; p < NP; p++) begin
				pol_q[p] <= vip_pkg::TAG_ALL;
				dvid_q[p] <= 12'd1;
				dpcp_q[p] <= 3'd0;
			end
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			lock_q <= lock_d;
			in_ok_q <= in_ok_d;
			if (ld_req) begin
				req_q <= in_data;
			end else if (state_q == vip_pkg::ST_SWEEP_RD && in_ok_q) begin
				req_q.req_type <= vip_pkg::REQ_RESET;
			end
			if (state_q == vip_pkg::ST_OUT) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			// port settings update
			if (state_q == vip_pkg::ST_EXEC && rq == vip_pkg::REQ_SET_PORT && port_ok) begin
				pol_q[req_q.port] <= req_q.mode[1:0];
				dvid_q[req_q.port] <= req_q.vid;
				dpcp_q[req_q.port] <= req_q.pcp;
			end
			if (ld_req && vip_pkg::req_e'(in_data.req_type) == vip_pkg::REQ_RESET) begin
				for (int p = 0; p < NP; p++) begin
					pol_q[p] <= in_data.mode[0] ? vip_pkg::TAG_RESTRICT : vip_pkg::TAG_ALL;
					dvid_q[p] <= 12'd1;
					dpcp_q[p] <= 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_res) res_q <= res_d;
	end

	// assertions
	`VIP_ASSERT_IMPL(a_no_take_busy, clk, arst_n, state_q != vip_pkg::ST_IDLE, in_stall)
	`VIP_ASSERT_IMPL(a_no_take_pending, clk, arst_n, out_valid_q, in_stall)
	`VIP_ASSERT_NEXT(a_out_after, clk, arst_n, state_q == vip_pkg::ST_OUT, out_valid_q)
endmodule
